### design/bounded_positional_deque_assert.svh
// Assertion macros shared by the deque checker.
`ifndef BOUNDED_POSITIONAL_DEQUE_ASSERT_SVH
`define BOUNDED_POSITIONAL_DEQUE_ASSERT_SVH

// Require cons in the same cycle whenever ante holds.
`define BPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed: same-cycle rule");

// Require cons in the cycle after ante holds.
`define BPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed: next-cycle rule");

`endif

### design/bpd_pkg.sv
// Package: sizes, codes and types of the positional deque.
package bpd_pkg;

    localparam int DEPTH   = 64;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int DATA_W  = 32;
    localparam int FUNC_W  = 3;
    localparam int POS_W   = 7;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [DATA_W-1:0] data_t;

    // Command codes
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INSERT_AT  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_REMOVE_AT  = 3'd5;
    localparam logic [FUNC_W-1:0] FN_READ_AT    = 3'd6;
    localparam logic [FUNC_W-1:0] FN_WRITE_AT   = 3'd7;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    // Operation kinds after decode
    localparam logic [1:0] K_OPEN  = 2'd0;
    localparam logic [1:0] K_CLOSE = 2'd1;
    localparam logic [1:0] K_READ  = 2'd2;
    localparam logic [1:0] K_WRITE = 2'd3;

    // Where an operation lands
    localparam logic [1:0] W_FRONT = 2'd0;
    localparam logic [1:0] W_BACK  = 2'd1;
    localparam logic [1:0] W_POS   = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [1:0]       where;
        data_t            value;
        logic [POS_W-1:0] position;
    } op_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        data_t             wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

### design/bpd_if.sv
// Interfaces: command and result channels of the positional deque.
interface bpd_cmd_if;
    import bpd_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]    position;

    modport source (output valid, output func, output value, output position, input ready);
    modport sink   (input valid, input func, input value, input position, output ready);
endinterface

interface bpd_res_if;
    import bpd_pkg::*;

    logic                valid;
    logic                ready;
    logic signed [DATA_W-1:0] read_data;
    logic [STAT_W-1:0]   status;
    logic [COUNT_W-1:0]  element_count;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;

    modport source (output valid, output read_data, output status, output element_count,
                    output front_value, output back_value, input ready);
    modport sink   (input valid, input read_data, input status, input element_count,
                    input front_value, input back_value, output ready);
endinterface

### design/bounded_positional_deque.sv
// A rejected command goes straight to the result; write at and read at access one
// entry; a push or insert moves the entries from the index up one place and writes
// the new one; a removal moves the later entries down one place and rereads the
// front and back unless it empties the store. Each moved entry costs one read and
// one write on the entry RAM. Commands queue while an operation runs or waits for the result register to free up.
// Reset empties the store at once; entries are not cleared and need no sweep.
module bounded_positional_deque (
    input  logic      clk,
    input  logic      rst_n,
    bpd_cmd_if.sink   cmd,
    bpd_res_if.source res
);
    import bpd_pkg::*;

    op_t      push_op, head_op;
    logic     push, queue_full, not_empty, q_pop;
    mem_req_t mem_req;
    logic [DATA_W-1:0] mem_rdata_raw;
    data_t    mem_rdata;

    assign mem_rdata = mem_rdata_raw;

    bpd_front u_front (
        .cmd        (cmd),
        .queue_full (queue_full),
        .push       (push),
        .push_op    (push_op)
    );

    bpd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .full      (queue_full),
        .pop       (q_pop),
        .not_empty (not_empty),
        .head_op   (head_op)
    );

    bpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (not_empty),
        .q_op      (head_op),
        .q_pop     (q_pop),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res       (res)
    );

    bpd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata_raw)
    );
endmodule

### design/bpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bpd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### design/bpd_front.sv
// Front end: accept command transactions and classify them into operations.
module bpd_front (
    bpd_cmd_if.sink        cmd,
    input  logic           queue_full,
    output logic           push,
    output bpd_pkg::op_t   push_op
);
    import bpd_pkg::*;

    // Take a transaction whenever the queue has room
    assign cmd.ready = !queue_full;
    assign push      = cmd.valid && !queue_full;

    // Classify the command by kind and landing place
    always_comb
    begin
        push_op.value    = cmd.value;
        push_op.position = cmd.position;
        case (cmd.func)
            FN_PUSH_FRONT: begin push_op.kind = K_OPEN;  push_op.where = W_FRONT; end
            FN_PUSH_BACK:  begin push_op.kind = K_OPEN;  push_op.where = W_BACK;  end
            FN_INSERT_AT:  begin push_op.kind = K_OPEN;  push_op.where = W_POS;   end
            FN_POP_FRONT:  begin push_op.kind = K_CLOSE; push_op.where = W_FRONT; end
            FN_POP_BACK:   begin push_op.kind = K_CLOSE; push_op.where = W_BACK;  end
            FN_REMOVE_AT:  begin push_op.kind = K_CLOSE; push_op.where = W_POS;   end
            FN_READ_AT:    begin push_op.kind = K_READ;  push_op.where = W_POS;   end
            default:       begin push_op.kind = K_WRITE; push_op.where = W_POS;   end
        endcase
    end
endmodule

### design/bpd_queue.sv
// Small operation queue between the front end and the execution unit.
module bpd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bpd_pkg::op_t  push_op,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output bpd_pkg::op_t  head_op
);
    import bpd_pkg::*;

    op_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    assign full      = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head_op   = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the pushed operation
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end
endmodule

### design/bpd_back.sv
// Execution unit: check, shift entries through the RAM and build results.
module bpd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  bpd_pkg::op_t         q_op,
    output logic                 q_pop,
    output bpd_pkg::mem_req_t    mem_req,
    input  bpd_pkg::data_t       mem_rdata,
    bpd_res_if.source            res
);
    import bpd_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ORD  = 4'd1;
    localparam logic [3:0] S_OWR  = 4'd2;
    localparam logic [3:0] S_PUT  = 4'd3;
    localparam logic [3:0] S_CRD  = 4'd4;
    localparam logic [3:0] S_CWR  = 4'd5;
    localparam logic [3:0] S_TRIM = 4'd6;
    localparam logic [3:0] S_FGET = 4'd7;
    localparam logic [3:0] S_BGET = 4'd8;
    localparam logic [3:0] S_RRD  = 4'd9;
    localparam logic [3:0] S_RGET = 4'd10;
    localparam logic [3:0] S_WR   = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    data_t             front_reg, front_next;
    data_t             back_reg, back_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    data_t             val_reg, val_next;
    logic [STAT_W-1:0] status_reg, status_next;
    data_t             rd_reg, rd_next;

    logic               out_valid_reg, out_valid_next;
    data_t              out_rd_reg;
    logic [STAT_W-1:0]  out_status_reg;
    logic [COUNT_W-1:0] out_count_reg;
    data_t              out_front_reg;
    data_t              out_back_reg;
    logic               out_load;

    logic [CNT_W-1:0]  ptr_dec, ptr_inc, cnt_dec;
    logic [CMP_W-1:0]  pos_c;
    logic [CNT_W-1:0]  pos_idx;
    logic              is_full, is_empty, in_range;
    logic [STAT_W-1:0] chk_status;
    logic [CNT_W-1:0]  chk_idx;

    assign ptr_dec  = ptr_reg - 1'b1;
    assign ptr_inc  = ptr_reg + 1'b1;
    assign cnt_dec  = count_reg - 1'b1;
    assign pos_c    = CMP_W'(q_op.position);
    assign pos_idx  = CNT_W'(pos_c - CMP_W'(1));
    assign is_full  = (count_reg >= CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign in_range = (pos_c != '0) && (pos_c <= CMP_W'(count_reg));

    // Check the head operation against the current count
    always_comb
    begin
        chk_status = ST_OK;
        chk_idx    = pos_idx;
        case (q_op.kind)
            K_OPEN:
            begin
                if (is_full)
                begin
                    chk_status = ST_FULL;
                end
                else if (q_op.where == W_FRONT)
                begin
                    chk_idx = '0;
                end
                else if (q_op.where == W_BACK)
                begin
                    chk_idx = count_reg;
                end
                else if (!(pos_c == CMP_W'(1) || in_range))
                begin
                    chk_status = ST_RANGE;
                end
            end
            K_CLOSE:
            begin
                if (is_empty)
                begin
                    chk_status = ST_EMPTY;
                end
                else if (q_op.where == W_FRONT)
                begin
                    chk_idx = '0;
                end
                else if (q_op.where == W_BACK)
                begin
                    chk_idx = cnt_dec;
                end
                else if (!in_range)
                begin
                    chk_status = ST_RANGE;
                end
            end
            default:
            begin
                if (is_empty)
                begin
                    chk_status = ST_EMPTY;
                end
                else if (!in_range)
                begin
                    chk_status = ST_RANGE;
                end
            end
        endcase
    end

    // Sequence the operation
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        front_next    = front_reg;
        back_next     = back_reg;
        idx_next      = idx_reg;
        ptr_next      = ptr_reg;
        val_next      = val_reg;
        status_next   = status_reg;
        rd_next       = rd_reg;
        q_pop         = 1'b0;
        out_load      = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.waddr = idx_reg[ADDR_W-1:0];
        mem_req.wdata = val_reg;
        mem_req.re    = 1'b0;
        mem_req.raddr = idx_reg[ADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    idx_next    = chk_idx;
                    val_next    = q_op.value;
                    status_next = chk_status;
                    rd_next     = '0;
                    if (chk_status != ST_OK)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        case (q_op.kind)
                            K_OPEN:
                            begin
                                ptr_next   = count_reg;
                                state_next = (chk_idx == count_reg) ? S_PUT : S_ORD;
                            end
                            K_CLOSE:
                            begin
                                ptr_next   = chk_idx;
                                state_next = (chk_idx == cnt_dec) ? S_TRIM : S_CRD;
                            end
                            K_READ:  state_next = S_RRD;
                            default: state_next = S_WR;
                        endcase
                    end
                end
            end
            // Open a slot: move entries up one place, from the back down
            S_ORD:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = ptr_dec[ADDR_W-1:0];
                state_next    = S_OWR;
            end
            S_OWR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ptr_reg[ADDR_W-1:0];
                mem_req.wdata = mem_rdata;
                ptr_next      = ptr_dec;
                state_next    = (ptr_dec == idx_reg) ? S_PUT : S_ORD;
            end
            S_PUT:
            begin
                mem_req.we = 1'b1;
                count_next = count_reg + 1'b1;
                if (idx_reg == '0)
                begin
                    front_next = val_reg;
                end
                if (idx_reg == count_reg)
                begin
                    back_next = val_reg;
                end
                state_next = S_DONE;
            end
            // Close a slot: move entries down one place, from the gap up
            S_CRD:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = ptr_inc[ADDR_W-1:0];
                state_next    = S_CWR;
            end
            S_CWR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ptr_reg[ADDR_W-1:0];
                mem_req.wdata = mem_rdata;
                ptr_next      = ptr_inc;
                state_next    = (ptr_inc == cnt_dec) ? S_TRIM : S_CRD;
            end
            S_TRIM:
            begin
                count_next = cnt_dec;
                if (cnt_dec == '0)
                begin
                    front_next = '0;
                    back_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = '0;
                    state_next    = S_FGET;
                end
            end
            // Refresh front and back after a removal
            S_FGET:
            begin
                front_next    = mem_rdata;
                mem_req.re    = 1'b1;
                mem_req.raddr = cnt_dec[ADDR_W-1:0];
                state_next    = S_BGET;
            end
            S_BGET:
            begin
                back_next  = mem_rdata;
                state_next = S_DONE;
            end
            S_RRD:
            begin
                mem_req.re = 1'b1;
                state_next = S_RGET;
            end
            S_RGET:
            begin
                rd_next    = mem_rdata;
                state_next = S_DONE;
            end
            S_WR:
            begin
                mem_req.we = 1'b1;
                if (idx_reg == '0)
                begin
                    front_next = val_reg;
                end
                if (idx_reg == cnt_dec)
                begin
                    back_next = val_reg;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold the result until the transaction completes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            front_reg     <= '0;
            back_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            front_reg     <= front_next;
            back_reg      <= back_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        ptr_reg    <= ptr_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        rd_reg     <= rd_next;
        if (out_load)
        begin
            out_rd_reg     <= rd_reg;
            out_status_reg <= status_reg;
            out_count_reg  <= COUNT_W'(count_reg);
            out_front_reg  <= front_reg;
            out_back_reg   <= back_reg;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.read_data     = out_rd_reg;
    assign res.status        = out_status_reg;
    assign res.element_count = out_count_reg;
    assign res.front_value   = out_front_reg;
    assign res.back_value    = out_back_reg;
endmodule

### design/bpd_checker.sv
// Checker on the result port of the deque, bound to the top level.
`include "bounded_positional_deque_assert.svh"

module bpd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic signed [31:0]           read_data,
    input logic [1:0]                   status,
    input logic [6:0]                   element_count,
    input logic signed [31:0]           front_value,
    input logic signed [31:0]           back_value
);
    import bpd_pkg::*;

    // Empty store shows zero at both ends
    `BPD_ASSERT_NOW(a_empty_ends, clk, rst_n, res_valid && (element_count == '0), (front_value == '0) && (back_value == '0))

    // A single element is both front and back
    `BPD_ASSERT_NOW(a_single_ends, clk, rst_n, res_valid && (element_count == COUNT_W'(1)), front_value == back_value)

    // Only a successful command returns read data
    `BPD_ASSERT_NOW(a_read_zero, clk, rst_n, res_valid && (status != ST_OK), read_data == '0)

    // A full status reports a full store
    `BPD_ASSERT_NOW(a_full_count, clk, rst_n, res_valid && (status == ST_FULL), element_count == COUNT_W'(DEPTH))

    // Hold a stalled result
    `BPD_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(read_data) && $stable(status) && $stable(element_count) && $stable(front_value) && $stable(back_value))
endmodule

bind bounded_positional_deque bpd_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .read_data     (res.read_data),
    .status        (res.status),
    .element_count (res.element_count),
    .front_value   (res.front_value),
    .back_value    (res.back_value)
);
